[hdl/symrbg_pkg.sv]
// ----------------------------------------------------------------------------
// symrbg_pkg
// Shared types, action codes and the word mask helper for the symbol by
// resource block occupancy grid.
// ----------------------------------------------------------------------------
package symrbg_pkg;

   localparam int WORD_BITS = 64;

   // action codes
   localparam logic [2:0] ACT_CLEAR    = 3'd0;
   localparam logic [2:0] ACT_FILL     = 3'd1;
   localparam logic [2:0] ACT_COLLIDES = 3'd2;
   localparam logic [2:0] ACT_ALLSET   = 3'd3;
   localparam logic [2:0] ACT_USED     = 3'd4;

   // classified command handed from front to back
   typedef struct packed {
      logic [2:0] action;
      logic       err;
      logic [3:0] sym_start;
      logic [3:0] sym_stop;
      logic [8:0] blk_lo;   // carrier-relative first block
      logic [8:0] blk_hi;   // carrier-relative stop block
      logic [8:0] lim_lo;   // clamped used-bitmap limits
      logic [8:0] lim_hi;
   } cmd_type;

   // mask of positions [lo, hi) inside the 64-bit word starting at base
   function automatic logic [63:0] word_mask(input logic [8:0] lo,
                                             input logic [8:0] hi,
                                             input logic [8:0] base);
      logic [8:0] da;
      logic [8:0] db;
      logic [6:0] sa;
      logic [6:0] sb;
      da = (lo > base) ? 9'(lo - base) : 9'd0;
      db = (hi > base) ? 9'(hi - base) : 9'd0;
      sa = (da > 9'd64) ? 7'd64 : da[6:0];
      sb = (db > 9'd64) ? 7'd64 : db[6:0];
      return ({64{1'b1}} << sa) & ~({64{1'b1}} << sb);
   endfunction

endpackage

[hdl/symrbg_ram.sv]
// ----------------------------------------------------------------------------
// symrbg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module symrbg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 70
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/symrbg_front.sv]
// ----------------------------------------------------------------------------
// symrbg_front
// Accepts commands, checks their ranges against the carrier, converts CRBs
// to carrier-relative positions and queues them for the back end.
// ----------------------------------------------------------------------------
module symrbg_front import symrbg_pkg::*; #(
   parameter int MAX_RBS     = 275,
   parameter int SYMBOL_ROWS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_sym_start,
   input  logic [3:0]  req_sym_stop,
   input  logic [11:0] req_crb_start,
   input  logic [11:0] req_crb_stop,
   input  logic [8:0]  req_lim_start,
   input  logic [8:0]  req_lim_stop,
   input  logic [11:0] carrier_offset,
   input  logic [8:0]  carrier_width,
   output cmd_type     cmd,
   output logic        cmd_valid,
   input  logic        cmd_pop
);

   logic [8:0]  width_eff;
   logic        sym_bad;
   logic        crb_bad;
   logic [12:0] crb_end;
   cmd_type     cls;
   cmd_type     q_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;

   // classify the incoming command
   always_comb begin
      width_eff = (carrier_width > 9'(MAX_RBS)) ? 9'(MAX_RBS) : carrier_width;
      crb_end   = 13'(carrier_offset) + 13'(width_eff);
      sym_bad   = (req_sym_start > req_sym_stop) || (req_sym_stop > 4'(SYMBOL_ROWS));
      crb_bad   = (req_crb_start > req_crb_stop) || (req_crb_start < carrier_offset)
                  || (13'(req_crb_stop) > crb_end);
      cls.action    = req_action;
      cls.sym_start = req_sym_start;
      cls.sym_stop  = req_sym_stop;
      cls.blk_lo    = 9'(req_crb_start - carrier_offset);
      cls.blk_hi    = 9'(req_crb_stop - carrier_offset);
      cls.lim_lo    = (req_lim_start > width_eff) ? width_eff : req_lim_start;
      cls.lim_hi    = (req_lim_stop > width_eff) ? width_eff : req_lim_stop;
      unique case (req_action) inside
         ACT_CLEAR:                          cls.err = 1'b0;
         ACT_USED:                           cls.err = sym_bad;
         ACT_FILL, ACT_COLLIDES, ACT_ALLSET: cls.err = sym_bad || crb_bad;
         default:                            cls.err = 1'b1;
      endcase
   end

   // two-entry queue toward the back end
   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = cmd_pop ? !rp_ff : rp_ff;
      cnt_in = 2'(cnt_ff + 2'(push) - 2'(cmd_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

[hdl/symrbg_back.sv]
// ----------------------------------------------------------------------------
// symrbg_back
// Carries out queued commands: walks the grid words of the chosen rows,
// marks, tests or ORs them, and drives the result register.
// ----------------------------------------------------------------------------
module symrbg_back import symrbg_pkg::*; #(
   parameter int MAX_RBS     = 275,
   parameter int SYMBOL_ROWS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   input  logic        clr_grid,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_error,
   output logic [2:0]  rsp_word_index,
   output logic [63:0] rsp_used_bits,
   output logic        rsp_last
);

   localparam int WORDS = (MAX_RBS + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH = SYMBOL_ROWS * WORDS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SCAN  = 4'b0010,
      S_DRAIN = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [3:0]  r_ff, r_in;
   logic [KW-1:0] k_ff, k_in, e_ff, e_in, p_k_ff, p_k_in;
   logic [AW-1:0] addr_ff, addr_in, p_addr_ff, p_addr_in;
   logic        p_vld_ff, p_vld_in;
   logic        vbit_ff, vbit_in;
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic        any_ff, any_in, all_ff, all_in;
   logic [63:0] acc_ff [WORDS];
   logic [63:0] acc_in [WORDS];
   logic        out_valid_ff, out_valid_in;
   logic        out_hit_ff, out_hit_in, out_err_ff, out_err_in, out_last_ff, out_last_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic [63:0] out_bits_ff, out_bits_in;
   logic        out_free;
   logic        rd_en, wr_en;
   logic [63:0] rd_data, word, mask, wr_data;
   logic        simple;

   symrbg_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign out_free = !out_valid_ff || !rsp_stall;
   assign simple   = cmd.err || (cmd.action == ACT_CLEAR);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      r_in      = r_ff;
      k_in      = k_ff;
      e_in      = e_ff;
      addr_in   = addr_ff;
      p_vld_in  = 1'b0;
      p_k_in    = k_ff;
      p_addr_in = addr_ff;
      vbit_in   = vld_ff[addr_ff];
      vld_in    = vld_ff;
      any_in    = any_ff;
      all_in    = all_ff;
      acc_in    = acc_ff;
      cmd_pop   = 1'b0;
      rd_en     = 1'b0;
      out_valid_in = out_free ? 1'b0 : out_valid_ff;
      out_hit_in   = out_hit_ff;
      out_err_in   = out_err_ff;
      out_idx_in   = out_idx_ff;
      out_bits_in  = out_bits_ff;
      out_last_in  = out_last_ff;

      // process the word read in the previous cycle
      word    = vbit_ff ? rd_data : 64'd0;
      mask    = word_mask(cmd_ff.blk_lo, cmd_ff.blk_hi, 9'(p_k_ff) << 6);
      wr_data = word | mask;
      wr_en   = p_vld_ff && (cmd_ff.action == ACT_FILL);
      if (wr_en) begin
         vld_in[p_addr_ff] = 1'b1;
      end
      if (p_vld_ff) begin
         if ((word & mask) != 64'd0) any_in = 1'b1;
         if ((word & mask) != mask)  all_in = 1'b0;
         acc_in[p_k_ff] = acc_ff[p_k_ff] | word;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (simple) begin
                  if (out_free) begin
                     cmd_pop      = 1'b1;
                     out_valid_in = 1'b1;
                     out_hit_in   = 1'b0;
                     out_err_in   = cmd.err;
                     out_idx_in   = 3'd0;
                     out_bits_in  = 64'd0;
                     out_last_in  = 1'b1;
                     if (!cmd.err) begin
                        vld_in = '0;
                     end
                  end
               end else begin
                  cmd_pop = 1'b1;
                  cmd_in  = cmd;
                  any_in  = 1'b0;
                  all_in  = 1'b1;
                  for (int i = 0; i < WORDS; i++) acc_in[i] = 64'd0;
                  r_in    = cmd.sym_start;
                  k_in    = '0;
                  addr_in = AW'(AW'(cmd.sym_start) * AW'(WORDS));
                  state_in = (cmd.sym_start == cmd.sym_stop) ? S_DRAIN : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one grid word read per cycle
            rd_en    = 1'b1;
            p_vld_in = 1'b1;
            addr_in  = AW'(addr_ff + 1'b1);
            if (k_ff == KW'(WORDS - 1)) begin
               k_in = '0;
               r_in = 4'(r_ff + 1'b1);
               if (r_ff == 4'(cmd_ff.sym_stop - 1'b1)) begin
                  state_in = S_DRAIN;
               end
            end else begin
               k_in = KW'(k_ff + 1'b1);
            end
         end
         S_DRAIN: begin
            if (!p_vld_ff) begin
               e_in     = '0;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = 1'b0;
               if (cmd_ff.action == ACT_USED) begin
                  out_hit_in  = 1'b0;
                  out_idx_in  = 3'(e_ff);
                  out_bits_in = acc_ff[0]
                                & word_mask(cmd_ff.lim_lo, cmd_ff.lim_hi, 9'(e_ff) << 6);
                  out_last_in = (e_ff == KW'(WORDS - 1));
                  for (int i = 0; i < WORDS - 1; i++) acc_in[i] = acc_ff[i + 1];
                  acc_in[WORDS - 1] = 64'd0;
                  e_in = KW'(e_ff + 1'b1);
                  if (e_ff == KW'(WORDS - 1)) state_in = S_IDLE;
               end else begin
                  out_hit_in  = (cmd_ff.action == ACT_COLLIDES) ? any_ff :
                                (cmd_ff.action == ACT_ALLSET) ? all_ff : 1'b0;
                  out_idx_in  = 3'd0;
                  out_bits_in = 64'd0;
                  out_last_in = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // carrier width write empties the grid
      if (clr_grid) begin
         vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p_vld_ff     <= 1'b0;
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_vld_ff     <= p_vld_in;
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff      <= cmd_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      e_ff        <= e_in;
      addr_ff     <= addr_in;
      p_k_ff      <= p_k_in;
      p_addr_ff   <= p_addr_in;
      vbit_ff     <= vbit_in;
      any_ff      <= any_in;
      all_ff      <= all_in;
      acc_ff      <= acc_in;
      out_hit_ff  <= out_hit_in;
      out_err_ff  <= out_err_in;
      out_idx_ff  <= out_idx_in;
      out_bits_ff <= out_bits_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_hit        = out_hit_ff;
   assign rsp_error      = out_err_ff;
   assign rsp_word_index = out_idx_ff;
   assign rsp_used_bits  = out_bits_ff;
   assign rsp_last       = out_last_ff;

endmodule

[hdl/symbol_rb_occupancy_grid.sv]
// ----------------------------------------------------------------------------
// symbol_rb_occupancy_grid
// Occupancy grid of symbol rows by carrier resource blocks with clear, fill,
// collision, all-set and used-bitmap commands.
//
//   channel   ports          direction  transfer when
//   request   req_*          in         req_valid && !req_stall
//   response  rsp_*          out        rsp_valid && !rsp_stall
//   config    psel/penable   in         psel && penable && pwrite
//
// Clear and refused commands are answered from the idle state. Other
// commands read the chosen rows one grid word per cycle through the RAM read
// port, then give one result, or one result per grid word for the used bitmap.
// Reset is synchronous; it empties the grid through per-word valid bits.
// A two-entry queue lets requests arrive while the back end works.
// ----------------------------------------------------------------------------
module symbol_rb_occupancy_grid import symrbg_pkg::*; #(
   parameter int MAX_RBS     = 275,
   parameter int SYMBOL_ROWS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_sym_start,
   input  logic [3:0]  req_sym_stop,
   input  logic [11:0] req_crb_start,
   input  logic [11:0] req_crb_stop,
   input  logic [8:0]  req_lim_start,
   input  logic [8:0]  req_lim_stop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_error,
   output logic [2:0]  rsp_word_index,
   output logic [63:0] rsp_used_bits,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [11:0] offset_ff, offset_in;
   logic [8:0]  width_ff, width_in;
   logic        csr_wr;
   logic        clr_grid;
   cmd_type     cmd;
   logic        cmd_valid;
   logic        cmd_pop;

   // register writes and read data
   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite;
   assign clr_grid = csr_wr && paddr[2];

   always_comb begin
      offset_in = offset_ff;
      width_in  = width_ff;
      if (csr_wr) begin
         if (paddr[2]) width_in  = pwdata[8:0];
         else          offset_in = pwdata[11:0];
      end
      prdata = paddr[2] ? 32'(width_ff) : 32'(offset_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 12'd0;
         width_ff  <= 9'd275;
      end else begin
         offset_ff <= offset_in;
         width_ff  <= width_in;
      end
   end

   symrbg_front #(.MAX_RBS(MAX_RBS), .SYMBOL_ROWS(SYMBOL_ROWS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_sym_start  (req_sym_start),
      .req_sym_stop   (req_sym_stop),
      .req_crb_start  (req_crb_start),
      .req_crb_stop   (req_crb_stop),
      .req_lim_start  (req_lim_start),
      .req_lim_stop   (req_lim_stop),
      .carrier_offset (offset_ff),
      .carrier_width  (width_ff),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   symrbg_back #(.MAX_RBS(MAX_RBS), .SYMBOL_ROWS(SYMBOL_ROWS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .clr_grid       (clr_grid),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_error      (rsp_error),
      .rsp_word_index (rsp_word_index),
      .rsp_used_bits  (rsp_used_bits),
      .rsp_last       (rsp_last)
   );

`ifndef SYNTHESIS
   // a hit only comes with a single-result answer
   a_hit_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_last && !rsp_error)
      else $error("hit on a non-final result");

   // refused commands carry no bitmap word
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && rsp_used_bits == 64'd0 && rsp_word_index == 3'd0)
      else $error("error result carries data");

   // nothing is presented right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");
`endif

endmodule
